// File: src/char_stream_tokenizer_top_macros.svh
// Assertion macros shared by the tokenizer checker.
`ifndef CHAR_STREAM_TOKENIZER_TOP_MACROS_SVH
`define CHAR_STREAM_TOKENIZER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CST_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/cst_pkg.sv
// Shared types, token codes and keyword table of the character stream tokenizer.
`default_nettype none

package cst_pkg;

   localparam int KEYWORD_MAX_LEN = 9;
   localparam int LENGTH_BITS     = 16;

   localparam int KIND_W   = 5;
   localparam int LINE_W   = 32;
   localparam int POS_W    = 32;
   localparam int TOKLEN_W = 16;

   localparam int RSP_DEPTH = 4;

   localparam logic [KIND_W-1:0] TK_PROGRAM   = 5'd0;
   localparam logic [KIND_W-1:0] TK_END       = 5'd1;
   localparam logic [KIND_W-1:0] TK_ELSE      = 5'd2;
   localparam logic [KIND_W-1:0] TK_IF        = 5'd3;
   localparam logic [KIND_W-1:0] TK_THEN      = 5'd4;
   localparam logic [KIND_W-1:0] TK_INTEGER   = 5'd5;
   localparam logic [KIND_W-1:0] TK_REAL      = 5'd6;
   localparam logic [KIND_W-1:0] TK_CHARACTER = 5'd7;
   localparam logic [KIND_W-1:0] TK_PRINT     = 5'd8;
   localparam logic [KIND_W-1:0] TK_LEN       = 5'd9;
   localparam logic [KIND_W-1:0] TK_PLUS      = 5'd10;
   localparam logic [KIND_W-1:0] TK_MINUS     = 5'd11;
   localparam logic [KIND_W-1:0] TK_MULT      = 5'd12;
   localparam logic [KIND_W-1:0] TK_DIV       = 5'd13;
   localparam logic [KIND_W-1:0] TK_POW       = 5'd14;
   localparam logic [KIND_W-1:0] TK_ASSOP     = 5'd15;
   localparam logic [KIND_W-1:0] TK_EQ        = 5'd16;
   localparam logic [KIND_W-1:0] TK_LTHAN     = 5'd17;
   localparam logic [KIND_W-1:0] TK_GTHAN     = 5'd18;
   localparam logic [KIND_W-1:0] TK_CAT       = 5'd19;
   localparam logic [KIND_W-1:0] TK_COMMA     = 5'd20;
   localparam logic [KIND_W-1:0] TK_LPAREN    = 5'd21;
   localparam logic [KIND_W-1:0] TK_RPAREN    = 5'd22;
   localparam logic [KIND_W-1:0] TK_DCOLON    = 5'd23;
   localparam logic [KIND_W-1:0] TK_DOT       = 5'd24;
   localparam logic [KIND_W-1:0] TK_DEF       = 5'd25;
   localparam logic [KIND_W-1:0] TK_ICONST    = 5'd26;
   localparam logic [KIND_W-1:0] TK_RCONST    = 5'd27;
   localparam logic [KIND_W-1:0] TK_SCONST    = 5'd28;
   localparam logic [KIND_W-1:0] TK_IDENT     = 5'd29;
   localparam logic [KIND_W-1:0] TK_ERR       = 5'd30;
   localparam logic [KIND_W-1:0] TK_DONE      = 5'd31;

   // Keyword spellings, upper case, left aligned and padded with spaces.
   localparam int KW_COUNT = 9;
   localparam int KW_CHARS = 9;
   localparam logic [KW_CHARS*8-1:0] KW_TEXT [KW_COUNT] = '{
      "PROGRAM  ", "END      ", "ELSE     ", "IF       ", "THEN     ",
      "INTEGER  ", "REAL     ", "CHARACTER", "PRINT    "
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd7, 4'd3, 4'd4, 4'd2, 4'd4, 4'd7, 4'd4, 4'd9, 4'd5
   };
   localparam logic [KIND_W-1:0] KW_KIND [KW_COUNT] = '{
      TK_PROGRAM, TK_END, TK_ELSE, TK_IF, TK_THEN,
      TK_INTEGER, TK_REAL, TK_CHARACTER, TK_PRINT
   };

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [LINE_W-1:0]   line;
      logic [POS_W-1:0]    start;
      logic [TOKLEN_W-1:0] length;
      logic                last;
   } token_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } scan_out_type;

   // Character i of the identifier sits at chars[8*i +: 8].
   // Bit 0 of flags: all upper case so far; bit 1: all lower case so far.
   function automatic logic [KIND_W-1:0] ident_kind(
      input logic [KW_CHARS*8-1:0] chars,
      input logic [TOKLEN_W-1:0]   len,
      input logic [1:0]            flags
   );
      logic [KIND_W-1:0] kind;
      logic              up;
      logic              lo;
      logic [7:0]        u;
      kind = TK_IDENT;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         up = flags[0];
         lo = flags[1];
         for (int i = 0; i < KW_CHARS; i++) begin
            u = KW_TEXT[k][8*(KW_CHARS-1-i) +: 8];
            if (i < int'(KW_LEN[k])) begin
               if (chars[8*i +: 8] != u) up = 1'b0;
               if (chars[8*i +: 8] != u + 8'd32) lo = 1'b0;
            end
         end
         if (len == {{(TOKLEN_W-4){1'b0}}, KW_LEN[k]} && (up || lo)) kind = KW_KIND[k];
      end
      return kind;
   endfunction

endpackage

`default_nettype wire

// File: src/cst_scanner.sv
// Scanner state and the one-character transition logic of the tokenizer.
`default_nettype none

module cst_scanner #(
   parameter int KEYWORD_MAX_LEN = cst_pkg::KEYWORD_MAX_LEN,
   parameter int LENGTH_BITS     = cst_pkg::LENGTH_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 take,
   input  wire logic [7:0]           char_code,
   input  wire logic                 end_of_input,
   output cst_pkg::scan_out_type     scan_out
);

   localparam int LEN_W = (LENGTH_BITS < cst_pkg::TOKLEN_W) ? LENGTH_BITS : cst_pkg::TOKLEN_W;
   localparam int IDX_W = $clog2(KEYWORD_MAX_LEN);
   localparam logic [LEN_W-1:0] LEN_CAP = '1;
   localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
   localparam logic [LEN_W-1:0] LEN_ZERO = '0;
   localparam logic [LEN_W-1:0] KW_MAX = LEN_W'(KEYWORD_MAX_LEN);

   localparam logic [3:0] M_START   = 4'd0;
   localparam logic [3:0] M_IDENT   = 4'd1;
   localparam logic [3:0] M_INT     = 4'd2;
   localparam logic [3:0] M_REAL    = 4'd3;
   localparam logic [3:0] M_STR_DQ  = 4'd4;
   localparam logic [3:0] M_STR_SQ  = 4'd5;
   localparam logic [3:0] M_COMMENT = 4'd6;
   localparam logic [3:0] M_STAR    = 4'd7;
   localparam logic [3:0] M_SLASH   = 4'd8;
   localparam logic [3:0] M_EQUAL   = 4'd9;
   localparam logic [3:0] M_COLON   = 4'd10;
   localparam logic [3:0] M_DOT     = 4'd11;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_UNDER   = 8'h5F;

   function automatic logic [LEN_W-1:0] len_inc(input logic [LEN_W-1:0] x);
      return (x == LEN_CAP) ? x : x + LEN_ONE;
   endfunction

   function automatic logic [31:0] sat_inc(input logic [31:0] x);
      return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return c >= 8'h41 && c <= 8'h5A;
   endfunction

   function automatic logic is_lower(input logic [7:0] c);
      return c >= 8'h61 && c <= 8'h7A;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return is_upper(c) || is_lower(c);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   logic [3:0]        mode_ff,   mode_in;
   logic [31:0]       line_ff,   line_in;
   logic [31:0]       pos_ff,    pos_in;
   logic [31:0]       lstart_ff, lstart_in;
   logic [LEN_W-1:0]  llen_ff,   llen_in;
   logic [1:0]        flags_ff,  flags_in;
   logic [7:0]        recent_ff [KEYWORD_MAX_LEN];

   logic              rc_we;
   logic [IDX_W-1:0]  rc_idx;
   logic [7:0]        rc_data;

   logic [cst_pkg::KW_CHARS*8-1:0] kw_chars;
   logic [cst_pkg::KIND_W-1:0]     id_kind;

   logic                           a_v, b_v, restart;
   logic [cst_pkg::KIND_W-1:0]     a_kind, b_kind;
   logic [31:0]                    a_start, b_start;
   logic [LEN_W-1:0]               a_len, b_len;
   cst_pkg::token_type             tok_a, tok_b;

   always_comb begin
      for (int i = 0; i < cst_pkg::KW_CHARS; i++) begin
         kw_chars[8*i +: 8] = recent_ff[i];
      end
      id_kind = cst_pkg::ident_kind(kw_chars, cst_pkg::TOKLEN_W'(llen_ff), flags_ff);
   end

   always_comb begin
      mode_in   = mode_ff;
      line_in   = line_ff;
      pos_in    = pos_ff;
      lstart_in = lstart_ff;
      llen_in   = llen_ff;
      flags_in  = flags_ff;
      rc_we     = 1'b0;
      rc_idx    = IDX_W'(llen_ff);
      rc_data   = char_code;
      a_v       = 1'b0;
      a_kind    = cst_pkg::TK_ERR;
      a_start   = lstart_ff;
      a_len     = LEN_ONE;
      b_v       = 1'b0;
      b_kind    = cst_pkg::TK_ERR;
      b_start   = pos_ff;
      b_len     = LEN_ONE;
      restart   = 1'b0;

      if (end_of_input) begin
         a_v = 1'b1;
         case (mode_ff)
            M_IDENT: begin
               a_kind = id_kind;
               a_len  = llen_ff;
            end
            M_INT: begin
               a_kind = cst_pkg::TK_ICONST;
               a_len  = llen_ff;
            end
            M_REAL: begin
               a_kind = cst_pkg::TK_RCONST;
               a_len  = llen_ff;
            end
            M_STR_DQ, M_STR_SQ: begin
               a_kind = cst_pkg::TK_ERR;
               a_len  = len_inc(llen_ff);
            end
            M_STAR:  a_kind = cst_pkg::TK_MULT;
            M_SLASH: a_kind = cst_pkg::TK_DIV;
            M_EQUAL: a_kind = cst_pkg::TK_ASSOP;
            M_COLON: a_kind = cst_pkg::TK_ERR;
            M_DOT:   a_kind = cst_pkg::TK_DOT;
            default: a_v = 1'b0;
         endcase
         b_v     = 1'b1;
         b_kind  = cst_pkg::TK_DONE;
         b_start = pos_ff;
         b_len   = LEN_ZERO;
         mode_in = M_START;
      end else begin
         pos_in = sat_inc(pos_ff);
         case (mode_ff)
            M_IDENT: begin
               if (is_alpha(char_code) || is_digit(char_code) || char_code == CH_UNDER) begin
                  rc_we = llen_ff < KW_MAX;
                  flags_in = flags_ff & {is_lower(char_code), is_upper(char_code)};
                  llen_in = len_inc(llen_ff);
               end else begin
                  a_v     = 1'b1;
                  a_kind  = id_kind;
                  a_len   = llen_ff;
                  restart = 1'b1;
               end
            end
            M_INT: begin
               if (is_digit(char_code)) begin
                  llen_in = len_inc(llen_ff);
               end else if (char_code == CH_DOT) begin
                  llen_in = len_inc(llen_ff);
                  mode_in = M_REAL;
               end else begin
                  a_v     = 1'b1;
                  a_kind  = cst_pkg::TK_ICONST;
                  a_len   = llen_ff;
                  restart = 1'b1;
               end
            end
            M_REAL: begin
               if (is_digit(char_code)) begin
                  llen_in = len_inc(llen_ff);
               end else if (char_code == CH_DOT) begin
                  a_v     = 1'b1;
                  a_kind  = cst_pkg::TK_ERR;
                  a_len   = len_inc(llen_ff);
                  mode_in = M_START;
               end else begin
                  a_v     = 1'b1;
                  a_kind  = cst_pkg::TK_RCONST;
                  a_len   = llen_ff;
                  restart = 1'b1;
               end
            end
            M_STR_DQ, M_STR_SQ: begin
               if (char_code == CH_NEWLINE) begin
                  a_v     = 1'b1;
                  a_kind  = cst_pkg::TK_ERR;
                  a_len   = len_inc(llen_ff);
                  line_in = sat_inc(line_ff);
                  mode_in = M_START;
               end else if ((mode_ff == M_STR_DQ && char_code == CH_DQUOTE) ||
                            (mode_ff == M_STR_SQ && char_code == CH_SQUOTE)) begin
                  a_v     = 1'b1;
                  a_kind  = cst_pkg::TK_SCONST;
                  a_start = sat_inc(lstart_ff);
                  a_len   = llen_ff;
                  mode_in = M_START;
               end else begin
                  llen_in = len_inc(llen_ff);
               end
            end
            M_COMMENT: begin
               if (char_code == CH_NEWLINE) begin
                  line_in = sat_inc(line_ff);
                  mode_in = M_START;
               end
            end
            M_STAR: begin
               a_v = 1'b1;
               if (char_code == CH_COMMA) begin
                  a_kind  = cst_pkg::TK_DEF;
                  restart = 1'b1;
               end else if (char_code == CH_STAR) begin
                  a_kind  = cst_pkg::TK_POW;
                  a_len   = len_inc(LEN_ONE);
                  mode_in = M_START;
               end else begin
                  a_kind  = cst_pkg::TK_MULT;
                  restart = 1'b1;
               end
            end
            M_SLASH: begin
               a_v = 1'b1;
               if (char_code == CH_SLASH) begin
                  a_kind  = cst_pkg::TK_CAT;
                  a_len   = len_inc(LEN_ONE);
                  mode_in = M_START;
               end else begin
                  a_kind  = cst_pkg::TK_DIV;
                  restart = 1'b1;
               end
            end
            M_EQUAL: begin
               a_v = 1'b1;
               if (char_code == CH_EQUAL) begin
                  a_kind  = cst_pkg::TK_EQ;
                  a_len   = len_inc(LEN_ONE);
                  mode_in = M_START;
               end else begin
                  a_kind  = cst_pkg::TK_ASSOP;
                  restart = 1'b1;
               end
            end
            M_COLON: begin
               a_v = 1'b1;
               if (char_code == CH_COLON) begin
                  a_kind  = cst_pkg::TK_DCOLON;
                  a_len   = len_inc(LEN_ONE);
                  mode_in = M_START;
               end else begin
                  a_kind  = cst_pkg::TK_ERR;
                  restart = 1'b1;
               end
            end
            M_DOT: begin
               if (is_digit(char_code)) begin
                  llen_in = len_inc(LEN_ONE);
                  mode_in = M_REAL;
               end else begin
                  a_v     = 1'b1;
                  a_kind  = cst_pkg::TK_DOT;
                  restart = 1'b1;
               end
            end
            default: restart = 1'b1;
         endcase

         // The current character begins a new lexeme from the start mode.
         if (restart) begin
            mode_in = M_START;
            if (char_code == CH_NEWLINE) line_in = sat_inc(line_ff);
            if (!is_space(char_code)) begin
               lstart_in = pos_ff;
               llen_in   = LEN_ONE;
               if (is_alpha(char_code)) begin
                  rc_we    = 1'b1;
                  rc_idx   = '0;
                  flags_in = {is_lower(char_code), is_upper(char_code)};
                  mode_in  = M_IDENT;
               end else if (is_digit(char_code)) begin
                  mode_in = M_INT;
               end else begin
                  case (char_code)
                     CH_DQUOTE: begin
                        llen_in = LEN_ZERO;
                        mode_in = M_STR_DQ;
                     end
                     CH_SQUOTE: begin
                        llen_in = LEN_ZERO;
                        mode_in = M_STR_SQ;
                     end
                     CH_BANG:   mode_in = M_COMMENT;
                     CH_STAR:   mode_in = M_STAR;
                     CH_SLASH:  mode_in = M_SLASH;
                     CH_EQUAL:  mode_in = M_EQUAL;
                     CH_COLON:  mode_in = M_COLON;
                     CH_DOT:    mode_in = M_DOT;
                     CH_PLUS: begin
                        b_v    = 1'b1;
                        b_kind = cst_pkg::TK_PLUS;
                     end
                     CH_MINUS: begin
                        b_v    = 1'b1;
                        b_kind = cst_pkg::TK_MINUS;
                     end
                     CH_GT: begin
                        b_v    = 1'b1;
                        b_kind = cst_pkg::TK_GTHAN;
                     end
                     CH_LT: begin
                        b_v    = 1'b1;
                        b_kind = cst_pkg::TK_LTHAN;
                     end
                     CH_LPAREN: begin
                        b_v    = 1'b1;
                        b_kind = cst_pkg::TK_LPAREN;
                     end
                     CH_RPAREN: begin
                        b_v    = 1'b1;
                        b_kind = cst_pkg::TK_RPAREN;
                     end
                     CH_COMMA: begin
                        b_v    = 1'b1;
                        b_kind = cst_pkg::TK_COMMA;
                     end
                     default: begin
                        b_v    = 1'b1;
                        b_kind = cst_pkg::TK_ERR;
                     end
                  endcase
               end
            end
         end
      end
   end

   // Every token of a step carries the line count held before the step.
   always_comb begin
      tok_a.kind   = a_kind;
      tok_a.line   = line_ff;
      tok_a.start  = a_start;
      tok_a.length = cst_pkg::TOKLEN_W'(a_len);
      tok_a.last   = !b_v;
      tok_b.kind   = b_kind;
      tok_b.line   = line_ff;
      tok_b.start  = b_start;
      tok_b.length = cst_pkg::TOKLEN_W'(b_len);
      tok_b.last   = 1'b1;
      if (a_v) begin
         scan_out.first  = tok_a;
         scan_out.second = tok_b;
         scan_out.count  = b_v ? 2'd2 : 2'd1;
      end else begin
         scan_out.first  = tok_b;
         scan_out.second = tok_b;
         scan_out.count  = b_v ? 2'd1 : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_START;
         line_ff   <= 32'd1;
         pos_ff    <= '0;
         lstart_ff <= '0;
         llen_ff   <= '0;
         flags_ff  <= 2'b11;
      end else if (take) begin
         mode_ff   <= mode_in;
         line_ff   <= line_in;
         pos_ff    <= pos_in;
         lstart_ff <= lstart_in;
         llen_ff   <= llen_in;
         flags_ff  <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && rc_we) begin
         recent_ff[rc_idx] <= rc_data;
      end
   end

endmodule

`default_nettype wire

// File: src/cst_rsp_fifo.sv
// Token queue that takes up to two tokens per cycle and hands out one.
`default_nettype none

module cst_rsp_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire cst_pkg::scan_out_type push_data,
   input  wire logic                  pop,
   output cst_pkg::token_type         head,
   output logic                       not_empty,
   output logic                       has_room
);

   localparam int DEPTH = cst_pkg::RSP_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cst_pkg::token_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   push_n;
   logic [PTR_W-1:0]   wr_next;

   always_comb begin
      push_n    = push ? CNT_W'(push_data.count) : '0;
      wr_next   = wr_ff + PTR_W'(1);
      wr_in     = wr_ff + PTR_W'(push_n);
      rd_in     = pop ? rd_ff + PTR_W'(1) : rd_ff;
      cnt_in    = cnt_ff + push_n - CNT_W'(pop);
      not_empty = cnt_ff != '0;
      has_room  = cnt_ff <= CNT_W'(DEPTH - 2);
      head      = mem_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && push_data.count != 2'd0) begin
         mem_ff[wr_ff] <= push_data.first;
      end
      if (push && push_data.count == 2'd2) begin
         mem_ff[wr_next] <= push_data.second;
      end
   end

endmodule

`default_nettype wire

// File: src/char_stream_tokenizer_top.sv
// Top level of the character stream tokenizer: scanner and token queue.
// One character is taken per cycle while req_ready is high; each step is decided in the cycle of its transfer.
// A token enters the registered token queue with the transfer of its character and is offered on rsp at the queue head.
// A step with two tokens delivers them in order; the rsp port moves one per cycle while rsp_ready is high.
// Synchronous reset returns to start mode with line 1 and position 0 and empties the queue.
`default_nettype none

module char_stream_tokenizer_top #(
   parameter int KEYWORD_MAX_LEN = cst_pkg::KEYWORD_MAX_LEN,
   parameter int LENGTH_BITS     = cst_pkg::LENGTH_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [7:0]                     req_char_code,
   input  wire logic                           req_end_of_input,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [cst_pkg::KIND_W-1:0]          rsp_token_kind,
   output logic [cst_pkg::LINE_W-1:0]          rsp_token_line,
   output logic [cst_pkg::POS_W-1:0]           rsp_token_start,
   output logic [cst_pkg::TOKLEN_W-1:0]        rsp_token_length,
   output logic                                rsp_last_of_run
);

   logic                  take;
   logic                  pop;
   logic                  has_room;
   cst_pkg::scan_out_type scan_out;
   cst_pkg::token_type    head;

   assign take      = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = has_room;

   cst_scanner #(
      .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
      .LENGTH_BITS     (LENGTH_BITS)
   ) u_scanner (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .char_code    (req_char_code),
      .end_of_input (req_end_of_input),
      .scan_out     (scan_out)
   );

   cst_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_data (scan_out),
      .pop       (pop),
      .head      (head),
      .not_empty (rsp_valid),
      .has_room  (has_room)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_token_line   = head.line;
   assign rsp_token_start  = head.start;
   assign rsp_token_length = head.length;
   assign rsp_last_of_run  = head.last;

endmodule

`default_nettype wire

// File: src/cst_checker.sv
// Port-level checker of the tokenizer and its bind to the top level.
`default_nettype none
`include "char_stream_tokenizer_top_macros.svh"

module cst_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic [7:0]                     req_char_code,
   input wire logic                           req_end_of_input,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [cst_pkg::KIND_W-1:0]     rsp_token_kind,
   input wire logic [cst_pkg::LINE_W-1:0]     rsp_token_line,
   input wire logic [cst_pkg::POS_W-1:0]      rsp_token_start,
   input wire logic [cst_pkg::TOKLEN_W-1:0]   rsp_token_length,
   input wire logic                           rsp_last_of_run
);

   logic req_seen;
   logic rsp_stall;

   assign req_seen  = req_valid || req_ready || req_end_of_input || (req_char_code != 8'd0);
   assign rsp_stall = rsp_valid && !rsp_ready;

   `CST_ASSERT_NOW(a_done_shape, rsp_valid && rsp_token_kind == cst_pkg::TK_DONE, rsp_token_length == '0 && rsp_last_of_run, "DONE transfer must have zero length and close its run")
   `CST_ASSERT_NOW(a_line_nonzero, rsp_valid, rsp_token_line != '0, "token line number is zero")
   `CST_ASSERT_NOW(a_empty_after_reset, $past(reset) && req_seen, !rsp_valid, "result offered right after reset")
   `CST_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_token_kind) && $stable(rsp_token_start) && $stable(rsp_token_length), "stalled result changed before its transfer")

endmodule

bind char_stream_tokenizer_top cst_checker u_cst_checker (.*);

`default_nettype wire

// File: test/tokenizer_checker.sv
// Checker for the tokenizer: predicts the token stream from accepted characters and compares it.
module tokenizer_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic [7:0]                             req_char_code,
   input  logic                                   req_end_of_input,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic [cst_pkg::KIND_W-1:0]             rsp_token_kind,
   input  logic [cst_pkg::LINE_W-1:0]             rsp_token_line,
   input  logic [cst_pkg::POS_W-1:0]              rsp_token_start,
   input  logic [cst_pkg::TOKLEN_W-1:0]           rsp_token_length,
   input  logic                                   rsp_last_of_run,
   output int                                     mismatch_count,
   output int                                     tokens_outstanding
);

   typedef enum logic [3:0] {
      SCAN_START, SCAN_IDENT, SCAN_INT, SCAN_REAL, SCAN_DQUOTE, SCAN_SQUOTE,
      SCAN_COMMENT, SCAN_STAR, SCAN_SLASH, SCAN_EQUAL, SCAN_COLON, SCAN_DOT
   } scan_mode_type;

   localparam int LEN_CAP = (cst_pkg::LENGTH_BITS >= 16) ? 65535 :
                            (1 << cst_pkg::LENGTH_BITS) - 1;

   localparam logic [cst_pkg::TOKLEN_W-1:0] LEN_ONE  = cst_pkg::TOKLEN_W'(1);
   localparam logic [cst_pkg::TOKLEN_W-1:0] LEN_ZERO = '0;

   localparam logic [7:0] CH_NEWLINE    = "\n";
   localparam logic [7:0] CH_DQUOTE     = "\"";
   localparam logic [7:0] CH_SQUOTE     = "'";
   localparam logic [7:0] CH_BANG       = "!";
   localparam logic [7:0] CH_PLUS       = "+";
   localparam logic [7:0] CH_MINUS      = "-";
   localparam logic [7:0] CH_STAR       = "*";
   localparam logic [7:0] CH_SLASH      = "/";
   localparam logic [7:0] CH_GREATER    = ">";
   localparam logic [7:0] CH_LESS       = "<";
   localparam logic [7:0] CH_EQUAL      = "=";
   localparam logic [7:0] CH_LPAREN     = "(";
   localparam logic [7:0] CH_RPAREN     = ")";
   localparam logic [7:0] CH_COMMA      = ",";
   localparam logic [7:0] CH_COLON      = ":";
   localparam logic [7:0] CH_DOT        = ".";
   localparam logic [7:0] CH_UNDERSCORE = "_";

   string keyword_spelling [cst_pkg::KW_COUNT] = '{
      "PROGRAM", "END", "ELSE", "IF", "THEN", "INTEGER", "REAL", "CHARACTER", "PRINT"
   };
   logic [cst_pkg::KIND_W-1:0] keyword_token [cst_pkg::KW_COUNT] = '{
      cst_pkg::TK_PROGRAM, cst_pkg::TK_END, cst_pkg::TK_ELSE, cst_pkg::TK_IF,
      cst_pkg::TK_THEN, cst_pkg::TK_INTEGER, cst_pkg::TK_REAL, cst_pkg::TK_CHARACTER,
      cst_pkg::TK_PRINT
   };

   scan_mode_type                 mode;
   logic [cst_pkg::LINE_W-1:0]    line_no;
   logic [cst_pkg::POS_W-1:0]     char_pos;
   logic [cst_pkg::POS_W-1:0]     lex_start;
   logic [cst_pkg::TOKLEN_W-1:0]  lex_len;
   logic [7:0]                    ident_chars [cst_pkg::KEYWORD_MAX_LEN];
   logic [1:0]                    case_ok;

   cst_pkg::token_type            step_buf [2];
   int                            step_count;
   cst_pkg::token_type            tokens_due [$];
   cst_pkg::token_type            want;
   logic [7:0]                    c;
   logic [cst_pkg::POS_W-1:0]     pos;

   function automatic logic [31:0] bump32(input logic [31:0] x);
      return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
   endfunction

   function automatic logic [cst_pkg::TOKLEN_W-1:0] bump_len(
      input logic [cst_pkg::TOKLEN_W-1:0] x
   );
      return (int'(x) < LEN_CAP) ? x + 1'b1 : x;
   endfunction

   function automatic logic is_letter(input logic [7:0] ch);
      logic [7:0] folded;
      folded = ch | 8'h20;
      return ch < 8'd128 && folded >= "a" && folded <= "z";
   endfunction

   function automatic logic is_digit(input logic [7:0] ch);
      return ch >= "0" && ch <= "9";
   endfunction

   function automatic logic is_blank(input logic [7:0] ch);
      return ch == " " || (ch >= 8'd9 && ch <= 8'd13);
   endfunction

   function automatic logic [cst_pkg::KIND_W-1:0] keyword_or_ident();
      logic [cst_pkg::KIND_W-1:0] kind;
      logic                       up;
      logic                       lo;
      logic [7:0]                 ch;
      string                      spelling;
      kind = cst_pkg::TK_IDENT;
      for (int k = 0; k < cst_pkg::KW_COUNT; k++) begin
         spelling = keyword_spelling[k];
         if (kind == cst_pkg::TK_IDENT && int'(lex_len) == spelling.len() &&
             spelling.len() <= cst_pkg::KEYWORD_MAX_LEN) begin
            up = case_ok[0];
            lo = case_ok[1];
            for (int i = 0; i < spelling.len(); i++) begin
               ch = spelling.getc(i);
               if (ident_chars[i] != ch) up = 1'b0;
               if (ident_chars[i] != ch + 8'd32) lo = 1'b0;
            end
            if (up || lo) kind = keyword_token[k];
         end
      end
      return kind;
   endfunction

   task automatic post_token(input logic [cst_pkg::KIND_W-1:0] kind,
                             input logic [cst_pkg::POS_W-1:0] start,
                             input logic [cst_pkg::TOKLEN_W-1:0] len);
      cst_pkg::token_type t;
      t.kind   = kind;
      t.line   = line_no;
      t.start  = start;
      t.length = len;
      t.last   = 1'b0;
      if (step_count < 2) begin
         step_buf[step_count] = t;
         step_count++;
      end
   endtask

   task automatic add_ident_char(input logic [7:0] ch);
      if (int'(lex_len) < cst_pkg::KEYWORD_MAX_LEN) ident_chars[lex_len] = ch;
      if (!(ch >= "A" && ch <= "Z")) case_ok[0] = 1'b0;
      if (!(ch >= "a" && ch <= "z")) case_ok[1] = 1'b0;
      lex_len = bump_len(lex_len);
   endtask

   task automatic begin_lexeme(input logic [7:0] ch, input logic [cst_pkg::POS_W-1:0] at);
      mode = SCAN_START;
      if (ch == CH_NEWLINE) line_no = bump32(line_no);
      if (!is_blank(ch)) begin
         lex_start = at;
         lex_len = LEN_ONE;
         if (is_letter(ch)) begin
            lex_len = LEN_ZERO;
            case_ok = 2'b11;
            add_ident_char(ch);
            mode = SCAN_IDENT;
         end else if (is_digit(ch)) begin
            mode = SCAN_INT;
         end else begin
            case (ch)
               CH_DQUOTE: begin
                  lex_len = LEN_ZERO;
                  mode = SCAN_DQUOTE;
               end
               CH_SQUOTE: begin
                  lex_len = LEN_ZERO;
                  mode = SCAN_SQUOTE;
               end
               CH_BANG:    mode = SCAN_COMMENT;
               CH_PLUS:    post_token(cst_pkg::TK_PLUS, at, LEN_ONE);
               CH_MINUS:   post_token(cst_pkg::TK_MINUS, at, LEN_ONE);
               CH_STAR:    mode = SCAN_STAR;
               CH_SLASH:   mode = SCAN_SLASH;
               CH_GREATER: post_token(cst_pkg::TK_GTHAN, at, LEN_ONE);
               CH_LESS:    post_token(cst_pkg::TK_LTHAN, at, LEN_ONE);
               CH_EQUAL:   mode = SCAN_EQUAL;
               CH_LPAREN:  post_token(cst_pkg::TK_LPAREN, at, LEN_ONE);
               CH_RPAREN:  post_token(cst_pkg::TK_RPAREN, at, LEN_ONE);
               CH_COMMA:   post_token(cst_pkg::TK_COMMA, at, LEN_ONE);
               CH_COLON:   mode = SCAN_COLON;
               CH_DOT:     mode = SCAN_DOT;
               default:    post_token(cst_pkg::TK_ERR, at, LEN_ONE);
            endcase
         end
      end
   endtask

   task automatic pair_token(input logic [7:0] ch, input logic [cst_pkg::POS_W-1:0] at,
                             input logic [7:0] second,
                             input logic [cst_pkg::KIND_W-1:0] both,
                             input logic [cst_pkg::KIND_W-1:0] single);
      if (ch == second) begin
         post_token(both, lex_start, bump_len(LEN_ONE));
         mode = SCAN_START;
      end else begin
         post_token(single, lex_start, LEN_ONE);
         begin_lexeme(ch, at);
      end
   endtask

   task automatic check_field(input string field, input logic [31:0] expected,
                              input logic [31:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s expected %0d, actual %0d", $time, field, expected, actual);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode = SCAN_START;
         line_no = cst_pkg::LINE_W'(1);
         char_pos = '0;
         lex_start = '0;
         lex_len = LEN_ZERO;
         case_ok = 2'b11;
         foreach (ident_chars[i]) ident_chars[i] = 8'h00;
         tokens_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (tokens_due.size() == 0) begin
               $display("%0t: token expected none, actual kind %0d line %0d start %0d",
                        $time, rsp_token_kind, rsp_token_line, rsp_token_start);
               mismatch_count++;
            end else begin
               want = tokens_due.pop_front();
               check_field("token_kind", want.kind, rsp_token_kind);
               check_field("token_line", want.line, rsp_token_line);
               check_field("token_start", want.start, rsp_token_start);
               check_field("token_length", want.length, rsp_token_length);
               check_field("last_of_run", want.last, rsp_last_of_run);
            end
         end
         if (req_valid && req_ready) begin
            step_count = 0;
            if (req_end_of_input) begin
               case (mode)
                  SCAN_IDENT:  post_token(keyword_or_ident(), lex_start, lex_len);
                  SCAN_INT:    post_token(cst_pkg::TK_ICONST, lex_start, lex_len);
                  SCAN_REAL:   post_token(cst_pkg::TK_RCONST, lex_start, lex_len);
                  SCAN_DQUOTE,
                  SCAN_SQUOTE: post_token(cst_pkg::TK_ERR, lex_start, bump_len(lex_len));
                  SCAN_STAR:   post_token(cst_pkg::TK_MULT, lex_start, LEN_ONE);
                  SCAN_SLASH:  post_token(cst_pkg::TK_DIV, lex_start, LEN_ONE);
                  SCAN_EQUAL:  post_token(cst_pkg::TK_ASSOP, lex_start, LEN_ONE);
                  SCAN_COLON:  post_token(cst_pkg::TK_ERR, lex_start, LEN_ONE);
                  SCAN_DOT:    post_token(cst_pkg::TK_DOT, lex_start, LEN_ONE);
                  default: ;
               endcase
               post_token(cst_pkg::TK_DONE, char_pos, LEN_ZERO);
               mode = SCAN_START;
            end else begin
               c = req_char_code;
               pos = char_pos;
               char_pos = bump32(char_pos);
               case (mode)
                  SCAN_IDENT: begin
                     if (is_letter(c) || is_digit(c) || c == CH_UNDERSCORE) begin
                        add_ident_char(c);
                     end else begin
                        post_token(keyword_or_ident(), lex_start, lex_len);
                        begin_lexeme(c, pos);
                     end
                  end
                  SCAN_INT: begin
                     if (is_digit(c)) begin
                        lex_len = bump_len(lex_len);
                     end else if (c == CH_DOT) begin
                        lex_len = bump_len(lex_len);
                        mode = SCAN_REAL;
                     end else begin
                        post_token(cst_pkg::TK_ICONST, lex_start, lex_len);
                        begin_lexeme(c, pos);
                     end
                  end
                  SCAN_REAL: begin
                     if (is_digit(c)) begin
                        lex_len = bump_len(lex_len);
                     end else if (c == CH_DOT) begin
                        post_token(cst_pkg::TK_ERR, lex_start, bump_len(lex_len));
                        mode = SCAN_START;
                     end else begin
                        post_token(cst_pkg::TK_RCONST, lex_start, lex_len);
                        begin_lexeme(c, pos);
                     end
                  end
                  SCAN_DQUOTE, SCAN_SQUOTE: begin
                     if (c == CH_NEWLINE) begin
                        post_token(cst_pkg::TK_ERR, lex_start, bump_len(lex_len));
                        line_no = bump32(line_no);
                        mode = SCAN_START;
                     end else if ((mode == SCAN_DQUOTE && c == CH_DQUOTE) ||
                                  (mode == SCAN_SQUOTE && c == CH_SQUOTE)) begin
                        post_token(cst_pkg::TK_SCONST, bump32(lex_start), lex_len);
                        mode = SCAN_START;
                     end else begin
                        lex_len = bump_len(lex_len);
                     end
                  end
                  SCAN_COMMENT: begin
                     if (c == CH_NEWLINE) begin
                        line_no = bump32(line_no);
                        mode = SCAN_START;
                     end
                  end
                  SCAN_STAR: begin
                     if (c == CH_COMMA) begin
                        post_token(cst_pkg::TK_DEF, lex_start, LEN_ONE);
                        begin_lexeme(c, pos);
                     end else begin
                        pair_token(c, pos, CH_STAR, cst_pkg::TK_POW, cst_pkg::TK_MULT);
                     end
                  end
                  SCAN_SLASH: pair_token(c, pos, CH_SLASH, cst_pkg::TK_CAT, cst_pkg::TK_DIV);
                  SCAN_EQUAL: pair_token(c, pos, CH_EQUAL, cst_pkg::TK_EQ, cst_pkg::TK_ASSOP);
                  SCAN_COLON: pair_token(c, pos, CH_COLON, cst_pkg::TK_DCOLON, cst_pkg::TK_ERR);
                  SCAN_DOT: begin
                     if (is_digit(c)) begin
                        lex_len = bump_len(LEN_ONE);
                        mode = SCAN_REAL;
                     end else begin
                        post_token(cst_pkg::TK_DOT, lex_start, LEN_ONE);
                        begin_lexeme(c, pos);
                     end
                  end
                  default: begin_lexeme(c, pos);
               endcase
            end
            if (step_count > 0) step_buf[step_count - 1].last = 1'b1;
            for (int i = 0; i < step_count; i++) tokens_due = {tokens_due, step_buf[i]};
         end
      end
      tokens_outstanding = tokens_due.size();
   end

endmodule

// File: test/tb.sv
// Testbench top for the tokenizer: clock, reset, character stimulus, backpressure and verdict.
module tb;

   localparam int CYCLE_LIMIT = 200000;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [7:0]                      req_char_code = 8'h00;
   logic                            req_end_of_input = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [cst_pkg::KIND_W-1:0]      rsp_token_kind;
   logic [cst_pkg::LINE_W-1:0]      rsp_token_line;
   logic [cst_pkg::POS_W-1:0]       rsp_token_start;
   logic [cst_pkg::TOKLEN_W-1:0]    rsp_token_length;
   logic                            rsp_last_of_run;
   int                              mismatch_count;
   int                              tokens_outstanding;

   int send_idle_pct = 20;
   int recv_idle_pct = 87;
   int items_sent = 0;
   int cycle_count = 0;

   string keywords [9] = '{
      "PROGRAM", "END", "ELSE", "IF", "THEN", "INTEGER", "REAL", "CHARACTER", "PRINT"
   };
   string operators [17] = '{
      "+", "-", "*", "/", "**", "//", "=", "==", ":", "::", ",", "(", ")", "<", ">", ".",
      "*,"
   };

   char_stream_tokenizer_top dut (.*);
   tokenizer_checker token_check (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("char_stream_tokenizer_top test failed");
         $finish;
      end
   end

   always @(negedge clock) rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

   task automatic send_item(input logic [7:0] ch, input logic eoi);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= ch;
      req_end_of_input <= eoi;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s.getc(i), 1'b0);
   endtask

   task automatic drain_tokens();
      req_valid <= 1'b0;
      @(negedge clock);
      while (tokens_outstanding != 0) @(negedge clock);
   endtask

   function automatic string ident_char();
      int r;
      r = $urandom_range(0, 62);
      if (r < 26) return $sformatf("%c", 65 + r);
      if (r < 52) return $sformatf("%c", 97 + r - 26);
      if (r < 62) return $sformatf("%c", 48 + r - 52);
      return "_";
   endfunction

   function automatic string digit_run(input int n);
      string s;
      s = "";
      for (int i = 0; i < n; i++) s = {s, $sformatf("%c", 48 + $urandom_range(0, 9))};
      return s;
   endfunction

   function automatic string printable_run(input int n, input int avoid);
      string s;
      int ch;
      s = "";
      for (int i = 0; i < n; i++) begin
         ch = $urandom_range(32, 126);
         if (ch == avoid) ch = "x";
         s = {s, $sformatf("%c", ch)};
      end
      return s;
   endfunction

   // Mostly well-formed lexemes with random content, some noise bytes, random separators.
   task automatic send_random_lexeme();
      string text;
      string spelling;
      int    pick;
      int    quote;
      text = "";
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
         spelling = keywords[$urandom_range(0, 8)];
         case ($urandom_range(0, 3))
            0: text = spelling;
            1: text = spelling.tolower();
            2: begin
               text = spelling.tolower();
               text.putc(0, spelling.getc(0));
            end
            default: text = {spelling, ident_char()};
         endcase
      end else if (pick < 30) begin
         text = $sformatf("%c", ($urandom_range(0, 1) ? 65 : 97) + $urandom_range(0, 25));
         repeat ($urandom_range(0, 11)) text = {text, ident_char()};
      end else if (pick < 42) begin
         text = digit_run($urandom_range(1, 6));
      end else if (pick < 52) begin
         case ($urandom_range(0, 3))
            0: text = {digit_run($urandom_range(1, 4)), ".", digit_run($urandom_range(0, 3))};
            1: text = {".", digit_run($urandom_range(1, 3))};
            2: text = {digit_run($urandom_range(1, 3)), ".", digit_run($urandom_range(0, 2)),
                       ".", digit_run($urandom_range(0, 2))};
            default: text = {digit_run($urandom_range(1, 3)), "."};
         endcase
      end else if (pick < 62) begin
         quote = $urandom_range(0, 1) ? "\"" : "'";
         text = {$sformatf("%c", quote), printable_run($urandom_range(0, 6), quote)};
         if ($urandom_range(0, 9) == 0) text = {text, "\n"};
         else text = {text, $sformatf("%c", quote)};
      end else if (pick < 68) begin
         text = {"!", printable_run($urandom_range(0, 8), 0), "\n"};
      end else if (pick < 88) begin
         text = operators[$urandom_range(0, 16)];
      end else begin
         send_item(8'($urandom_range(0, 255)), 1'b0);
      end
      send_text(text);
      case ($urandom_range(0, 9))
         0, 1, 2: ;
         3, 4, 5: send_text(" ");
         6:       send_text("\n");
         7:       send_item(8'($urandom_range(9, 13)), 1'b0);
         8:       send_text("  ");
         default: send_text("\t\n");
      endcase
      if ($urandom_range(0, 39) == 0) send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: lookahead pairs, a second dot in a real, a newline in a string,
      // unknown bytes, and a lone colon flushed by the end of input.
      send_text("THEN *,**/==:: .7.. 'a\n");
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_text(":");
      send_item(8'hA5, 1'b1);

      while (items_sent < 230) send_random_lexeme();
      drain_tokens();
      send_idle_pct = 87;
      recv_idle_pct = 20;
      while (items_sent < 450) send_random_lexeme();
      drain_tokens();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (items_sent < 645) send_random_lexeme();
      send_item(8'($urandom_range(0, 255)), 1'b1);
      drain_tokens();
      repeat (20) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("char_stream_tokenizer_top test passed");
      end else begin
         $display("char_stream_tokenizer_top test failed");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+src
src/cst_pkg.sv
src/cst_scanner.sv
src/cst_rsp_fifo.sv
src/char_stream_tokenizer_top.sv
src/cst_checker.sv
test/tokenizer_checker.sv
test/tb.sv
